// ===== hw/rtl/lbad_pkg.sv =====
// ----------------------------------------------------------------------------
// lbad_pkg
// Shared types and constants of the LED blink and alert mode driver.
// ----------------------------------------------------------------------------
`default_nettype none

package lbad_pkg;

    localparam int LEVEL_W  = 9;
    localparam int PERIOD_W = 8;
    localparam int BLINKS_W = 4;
    localparam int TOGGLE_W = BLINKS_W + 1;
    localparam int OP_W     = 3;
    localparam int CODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MIX_W    = 17;

    localparam logic [LEVEL_W-1:0]  FULL_LEVEL      = 9'd256;
    localparam logic [LEVEL_W-1:0]  FOCUS_THRESH    = 9'd128;
    localparam logic [LEVEL_W-1:0]  FOCUS_LO_BASE   = 9'd108;
    localparam logic [LEVEL_W-1:0]  FOCUS_LO_BLINK  = 9'd20;
    localparam logic [MIX_W-1:0]    FOCUS_HI_GAIN   = 17'd174;
    localparam logic [MIX_W-1:0]    FOCUS_HI_BLINK  = 17'd20992;
    localparam logic [MIX_W-1:0]    FOCUS_ROUND     = 17'd128;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 8'd20;
    localparam logic [PERIOD_W-1:0] ALERT_PERIOD_RST = 8'd23;
    localparam logic [BLINKS_W-1:0] ALERT_BLINKS_RST = 4'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SET_LEVEL  = 3'd1,
        OP_FOCUS      = 3'd2,
        OP_VALUE      = 3'd3,
        OP_ALERT      = 3'd4,
        OP_BLINK_ONCE = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK_PERIOD = 2'd0,
        CFG_ALERT_PERIOD = 2'd1,
        CFG_ALERT_BLINKS = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MODE_VALUE = 4'b0001,
        MODE_FOCUS = 4'b0010,
        MODE_ALERT = 4'b0100,
        MODE_ONCE  = 4'b1000
    } t_mode;

    localparam logic [CODE_W-1:0] CODE_VALUE = 2'd0;
    localparam logic [CODE_W-1:0] CODE_FOCUS = 2'd1;
    localparam logic [CODE_W-1:0] CODE_ALERT = 2'd2;
    localparam logic [CODE_W-1:0] CODE_ONCE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] brightness;
        logic [CODE_W-1:0]  mode;
    } t_result;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [PERIOD_W-1:0]  data;
    } t_cfg_wr;

    function automatic logic [CODE_W-1:0] mode_code(input t_mode m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_VALUE: c = CODE_VALUE;
            MODE_FOCUS: c = CODE_FOCUS;
            MODE_ALERT: c = CODE_ALERT;
            MODE_ONCE:  c = CODE_ONCE;
            default:    c = CODE_VALUE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lbad_in_stage.sv =====
// ----------------------------------------------------------------------------
// lbad_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbad_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire lbad_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_valid,
    output lbad_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    lbad_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lbad_core.sv =====
// ----------------------------------------------------------------------------
// lbad_core
// Mode state, blink timers and brightness for one request per cycle while i_adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lbad_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lbad_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_adv,
    input  wire lbad_pkg::t_item   i_item,
    output logic                   o_res_valid,
    output lbad_pkg::t_result      o_res
);

    logic [lbad_pkg::PERIOD_W-1:0] r_blink_period;
    logic [lbad_pkg::PERIOD_W-1:0] r_alert_period;
    logic [lbad_pkg::BLINKS_W-1:0] r_alert_blinks;

    lbad_pkg::t_mode               r_mode;
    lbad_pkg::t_mode               n_mode;
    lbad_pkg::t_mode               r_ret;
    lbad_pkg::t_mode               n_ret;
    logic [lbad_pkg::LEVEL_W-1:0]  r_level;
    logic [lbad_pkg::LEVEL_W-1:0]  n_level;
    logic                          r_bit;
    logic                          n_bit;
    logic [lbad_pkg::PERIOD_W-1:0] r_period;
    logic [lbad_pkg::PERIOD_W-1:0] n_period;
    logic [lbad_pkg::TOGGLE_W-1:0] r_toggles;
    logic [lbad_pkg::TOGGLE_W-1:0] n_toggles;

    logic                          w_in_blink;
    logic                          w_period_exp;
    logic                          w_toggles_exp;
    logic [lbad_pkg::MIX_W-1:0]    w_mix;
    logic [lbad_pkg::LEVEL_W-1:0]  w_focus;
    logic [lbad_pkg::LEVEL_W-1:0]  w_bright;
    logic [lbad_pkg::LEVEL_W-1:0]  w_flash;
    logic [lbad_pkg::TOGGLE_W-1:0] w_toggle_load;

    assign w_in_blink    = (r_mode == lbad_pkg::MODE_ALERT) || (r_mode == lbad_pkg::MODE_ONCE);
    assign w_period_exp  = (r_period <= lbad_pkg::PERIOD_W'(1));
    assign w_toggles_exp = (r_toggles <= lbad_pkg::TOGGLE_W'(1));
    assign w_toggle_load = {r_alert_blinks, 1'b0};
    assign w_flash       = r_bit ? lbad_pkg::FULL_LEVEL : '0;

    assign w_mix = lbad_pkg::MIX_W'(r_level) * lbad_pkg::FOCUS_HI_GAIN
                 + (r_bit ? lbad_pkg::FOCUS_HI_BLINK : '0)
                 + lbad_pkg::FOCUS_ROUND;

    always_comb begin
        if (r_level > lbad_pkg::FOCUS_THRESH) begin
            w_focus = w_mix[lbad_pkg::MIX_W-1:8];
        end else begin
            w_focus = lbad_pkg::FOCUS_LO_BASE + (r_bit ? lbad_pkg::FOCUS_LO_BLINK : '0);
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_ret       = r_ret;
        n_level     = r_level;
        n_bit       = r_bit;
        n_period    = r_period;
        n_toggles   = r_toggles;
        w_bright    = '0;
        o_res_valid = 1'b0;
        if (i_adv) begin
            unique case (lbad_pkg::t_op'(i_item.op))
                lbad_pkg::OP_SET_LEVEL: begin
                    n_level = (i_item.level > lbad_pkg::FULL_LEVEL) ?
                              lbad_pkg::FULL_LEVEL : i_item.level;
                end
                lbad_pkg::OP_FOCUS: begin
                    if (w_in_blink) begin
                        n_ret = lbad_pkg::MODE_FOCUS;
                    end else begin
                        n_mode = lbad_pkg::MODE_FOCUS;
                    end
                end
                lbad_pkg::OP_VALUE: begin
                    n_mode = lbad_pkg::MODE_VALUE;
                end
                lbad_pkg::OP_ALERT: begin
                    n_bit    = 1'b0;
                    n_period = r_alert_period;
                    if (!w_in_blink) begin
                        n_ret = r_mode;
                    end
                    n_mode = lbad_pkg::MODE_ALERT;
                end
                lbad_pkg::OP_BLINK_ONCE: begin
                    if (!w_in_blink) begin
                        n_bit    = (r_level == '0);
                        n_period = r_blink_period;
                        n_ret    = r_mode;
                        n_mode   = lbad_pkg::MODE_ONCE;
                    end
                end
                lbad_pkg::OP_TICK: begin
                    o_res_valid = 1'b1;
                    unique case (r_mode)
                        lbad_pkg::MODE_VALUE: begin
                            w_bright = r_level;
                        end
                        lbad_pkg::MODE_FOCUS: begin
                            w_bright = w_focus;
                            if (w_period_exp) begin
                                n_period = r_alert_period;
                                n_bit    = !r_bit;
                            end else begin
                                n_period = r_period - 1'b1;
                            end
                        end
                        lbad_pkg::MODE_ALERT: begin
                            w_bright = w_flash;
                            if (w_period_exp) begin
                                if (w_toggles_exp) begin
                                    n_toggles = w_toggle_load;
                                    n_mode    = r_ret;
                                end else begin
                                    n_toggles = r_toggles - 1'b1;
                                end
                                n_bit    = !r_bit;
                                n_period = r_alert_period;
                            end else begin
                                n_period = r_period - 1'b1;
                            end
                        end
                        lbad_pkg::MODE_ONCE: begin
                            w_bright = w_flash;
                            if (w_period_exp) begin
                                n_bit    = !r_bit;
                                n_mode   = r_ret;
                                n_period = r_blink_period;
                            end else begin
                                n_period = r_period - 1'b1;
                            end
                        end
                        default: begin
                            w_bright = '0;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.brightness = w_bright;
    assign o_res.mode       = lbad_pkg::mode_code(r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period <= lbad_pkg::BLINK_PERIOD_RST;
            r_alert_period <= lbad_pkg::ALERT_PERIOD_RST;
            r_alert_blinks <= lbad_pkg::ALERT_BLINKS_RST;
        end else if (i_cfg.valid) begin
            unique case (lbad_pkg::t_cfg_idx'(i_cfg.index))
                lbad_pkg::CFG_BLINK_PERIOD: r_blink_period <= i_cfg.data;
                lbad_pkg::CFG_ALERT_PERIOD: r_alert_period <= i_cfg.data;
                lbad_pkg::CFG_ALERT_BLINKS: r_alert_blinks <= i_cfg.data[lbad_pkg::BLINKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lbad_pkg::MODE_VALUE;
            r_ret     <= lbad_pkg::MODE_VALUE;
            r_level   <= '0;
            r_bit     <= 1'b0;
            r_period  <= lbad_pkg::BLINK_PERIOD_RST;
            r_toggles <= {lbad_pkg::ALERT_BLINKS_RST, 1'b0};
        end else begin
            r_mode    <= n_mode;
            r_ret     <= n_ret;
            r_level   <= n_level;
            r_bit     <= n_bit;
            r_period  <= n_period;
            r_toggles <= n_toggles;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lbad_out_stage.sv =====
// ----------------------------------------------------------------------------
// lbad_out_stage
// Result register with a skid entry, so one result can wait without stalling input.
// ----------------------------------------------------------------------------
`default_nettype none

module lbad_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire lbad_pkg::t_result i_res,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lbad_pkg::t_result      o_res
);

    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_skid_valid;
    logic              n_skid_valid;
    lbad_pkg::t_result r_out;
    lbad_pkg::t_result r_skid;
    logic              w_pop;
    logic              w_load_out;
    logic              w_load_skid;
    logic              w_from_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign w_pop   = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        w_from_skid  = 1'b0;
        if (i_push && (!r_out_valid || w_pop)) begin
            n_out_valid = 1'b1;
            w_load_out  = 1'b1;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            w_load_skid  = 1'b1;
        end else if (w_pop && r_skid_valid) begin
            n_skid_valid = 1'b0;
            w_from_skid  = 1'b1;
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= i_res;
        end else if (w_from_skid) begin
            r_out <= r_skid;
        end
        if (w_load_skid) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/led_blink_alert_mode_driver_core.sv =====
// ----------------------------------------------------------------------------
// led_blink_alert_mode_driver_core
// LED brightness driver with value, focus, alert and single-blink modes.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tuser op, tdata level
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata brightness, mode
//   cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request per cycle while the skid entry is free; ticks give results.
// The whole mode and timer update sits between the input and result registers.
// Reset restores register defaults and value mode with zero level.
// A stalled result is held in a skid entry; input stops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_alert_mode_driver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [8:0] level
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [8:0] brightness, [10:9] mode
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    lbad_pkg::t_item   w_in_item;
    lbad_pkg::t_item   w_item;
    lbad_pkg::t_result w_res;
    lbad_pkg::t_result w_out_res;
    lbad_pkg::t_cfg_wr w_cfg;
    logic              w_item_valid;
    logic              w_out_space;
    logic              w_adv;
    logic              w_res_valid;

    assign w_in_item.op    = s_axis_tuser;
    assign w_in_item.level = s_axis_tdata[lbad_pkg::LEVEL_W-1:0];

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign w_adv = w_item_valid && w_out_space;

    lbad_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_adv),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    lbad_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lbad_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_out_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = {5'd0, w_out_res.mode, w_out_res.brightness};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_out_space |-> m_axis_tvalid)
        else $error("skid entry full while result register empty");

    a_result_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_adv && (w_item.op == lbad_pkg::OP_TICK)))
        else $error("result raised without an accepted tick");

    a_result_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> m_axis_tvalid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== bench/led_blink_alert_mode_driver_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_blink_alert_mode_driver_core_test
// Self-checking bench for the LED value, focus, alert and single-blink driver.
//
// Requests enter on the slave stream, and tick results leave on the master
// stream. A scoreboard keeps its own copy of the mode, level and blink timer
// state and predicts every tick. A short directed list covers the level clamp,
// the spare op codes and the mode requests made during blinking. Random phases
// follow, each with its own register setting: zero, one, the widest values,
// small values and random ones. Both sides idle at random, and once the result
// side holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------

module led_blink_alert_mode_driver_core_test;

    localparam logic [lbad_pkg::OP_W-1:0]      OP_SPARE_LO    = 3'd6;
    localparam logic [lbad_pkg::OP_W-1:0]      OP_SPARE_HI    = 3'd7;
    localparam logic [lbad_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 17;

    class brightness_scoreboard;
        logic [lbad_pkg::PERIOD_W-1:0] blink_period;
        logic [lbad_pkg::PERIOD_W-1:0] alert_period;
        logic [lbad_pkg::BLINKS_W-1:0] alert_blinks;
        logic [lbad_pkg::CODE_W-1:0]   cur_mode;
        logic [lbad_pkg::CODE_W-1:0]   ret_mode;
        logic [lbad_pkg::LEVEL_W-1:0]  steady;
        logic                          blink;
        logic [lbad_pkg::PERIOD_W-1:0] period_left;
        logic [lbad_pkg::TOGGLE_W-1:0] toggles_left;
        lbad_pkg::t_result             due_ticks[$];
        int errors;
        int requests;
        int ticks_seen;
        int alert_returns;
        int once_returns;
        int mode_hits[4];

        function new();
            blink_period = lbad_pkg::BLINK_PERIOD_RST;
            alert_period = lbad_pkg::ALERT_PERIOD_RST;
            alert_blinks = lbad_pkg::ALERT_BLINKS_RST;
            cur_mode = lbad_pkg::CODE_VALUE;
            ret_mode = lbad_pkg::CODE_VALUE;
            steady = '0;
            blink = 1'b0;
            period_left = lbad_pkg::BLINK_PERIOD_RST;
            toggles_left = {lbad_pkg::ALERT_BLINKS_RST, 1'b0};
            errors = 0;
            requests = 0;
            ticks_seen = 0;
            alert_returns = 0;
            once_returns = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        function bit blinking();
            return cur_mode == lbad_pkg::CODE_ALERT || cur_mode == lbad_pkg::CODE_ONCE;
        endfunction

        function void write_reg(logic [lbad_pkg::CFG_IDX_W-1:0] idx,
                                logic [lbad_pkg::PERIOD_W-1:0] data);
            case (idx)
                lbad_pkg::CFG_BLINK_PERIOD: blink_period = data;
                lbad_pkg::CFG_ALERT_PERIOD: alert_period = data;
                lbad_pkg::CFG_ALERT_BLINKS: alert_blinks = data[lbad_pkg::BLINKS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [lbad_pkg::OP_W-1:0] op,
                                   logic [lbad_pkg::LEVEL_W-1:0] lvl);
            lbad_pkg::t_result r;
            int unsigned       mix;
            requests++;
            case (op)
                lbad_pkg::OP_SET_LEVEL:
                    steady = (lvl > lbad_pkg::FULL_LEVEL) ? lbad_pkg::FULL_LEVEL : lvl;
                lbad_pkg::OP_FOCUS: begin
                    if (blinking()) ret_mode = lbad_pkg::CODE_FOCUS;
                    else cur_mode = lbad_pkg::CODE_FOCUS;
                end
                lbad_pkg::OP_VALUE: cur_mode = lbad_pkg::CODE_VALUE;
                lbad_pkg::OP_ALERT: begin
                    blink = 1'b0;
                    period_left = alert_period;
                    if (!blinking()) ret_mode = cur_mode;
                    cur_mode = lbad_pkg::CODE_ALERT;
                end
                lbad_pkg::OP_BLINK_ONCE: begin
                    if (!blinking()) begin
                        blink = (steady == 0);
                        period_left = blink_period;
                        ret_mode = cur_mode;
                        cur_mode = lbad_pkg::CODE_ONCE;
                    end
                end
                lbad_pkg::OP_TICK: begin
                    r.mode = cur_mode;
                    case (cur_mode)
                        lbad_pkg::CODE_VALUE: r.brightness = steady;
                        lbad_pkg::CODE_FOCUS: begin
                            // 0.68 / 0.32 mix above half level, fixed 0.42 / 0.08 below
                            if (steady > 9'd128) begin
                                mix = 174 * steady + (blink ? 82 * 256 : 0) + 128;
                                r.brightness = mix[16:8];
                            end else begin
                                r.brightness = blink ? 9'd128 : 9'd108;
                            end
                            if (period_left <= 1) begin
                                period_left = alert_period;
                                blink = ~blink;
                            end else begin
                                period_left--;
                            end
                        end
                        lbad_pkg::CODE_ALERT: begin
                            r.brightness = blink ? lbad_pkg::FULL_LEVEL : 9'd0;
                            if (period_left <= 1) begin
                                if (toggles_left <= 1) begin
                                    toggles_left = {alert_blinks, 1'b0};
                                    cur_mode = ret_mode;
                                    alert_returns++;
                                end else begin
                                    toggles_left--;
                                end
                                blink = ~blink;
                                period_left = alert_period;
                            end else begin
                                period_left--;
                            end
                        end
                        default: begin
                            r.brightness = blink ? lbad_pkg::FULL_LEVEL : 9'd0;
                            if (period_left <= 1) begin
                                blink = ~blink;
                                cur_mode = ret_mode;
                                period_left = blink_period;
                                once_returns++;
                            end else begin
                                period_left--;
                            end
                        end
                    endcase
                    due_ticks = {due_ticks, r};
                end
                default: ;
            endcase
        endfunction

        function void check_tick(logic [15:0] data);
            lbad_pkg::t_result             want;
            logic [lbad_pkg::LEVEL_W-1:0]  got_bright;
            logic [lbad_pkg::CODE_W-1:0]   got_mode;
            got_bright = data[8:0];
            got_mode = data[10:9];
            if (due_ticks.size() == 0) begin
                errors++;
                $display("%0t: unexpected tick: expected none, got brightness %0d mode %0d",
                         $time, got_bright, got_mode);
                return;
            end
            want = due_ticks.pop_front();
            ticks_seen++;
            mode_hits[want.mode]++;
            if (got_bright !== want.brightness || got_mode !== want.mode) begin
                errors++;
                $display("%0t: tick mismatch: expected brightness %0d mode %0d,",
                         $time, want.brightness, want.mode,
                         " got brightness %0d mode %0d", got_bright, got_mode);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [8:0] level
    logic [2:0]  s_axis_tuser = '0;   // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [8:0] brightness, [10:9] mode
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    brightness_scoreboard sb;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit rx_hold = 1'b0;
    int phases = 0;

    led_blink_alert_mode_driver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_tick(m_axis_tdata);
    end

    // result side: random stalls, eager stretches and one long hold-off
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                stall = LONG_HOLD;
                rx_hold = 1'b0;
            end else if (rx_eager || $urandom_range(0, 3) == 0) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(logic [lbad_pkg::OP_W-1:0] op,
                                logic [lbad_pkg::LEVEL_W-1:0] lvl);
        int gap;
        gap = (tx_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, lvl);
    endtask

    task automatic write_reg(logic [lbad_pkg::CFG_IDX_W-1:0] idx,
                             logic [lbad_pkg::PERIOD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic settle_idle();
        while (sb.due_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_request(output logic [lbad_pkg::OP_W-1:0] op,
                                output logic [lbad_pkg::LEVEL_W-1:0] lvl);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) op = lbad_pkg::OP_TICK;
        else if (r < 78) op = lbad_pkg::OP_SET_LEVEL;
        else if (r < 83) op = lbad_pkg::OP_FOCUS;
        else if (r < 88) op = lbad_pkg::OP_VALUE;
        else if (r < 93) op = lbad_pkg::OP_ALERT;
        else if (r < 98) op = lbad_pkg::OP_BLINK_ONCE;
        else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        case ($urandom_range(0, 9))
            0: lvl = 9'd0;
            1: lvl = lbad_pkg::FULL_LEVEL;
            2: lvl = 9'd128;
            3: lvl = 9'd129;
            4: lvl = 9'($urandom_range(257, 511));
            default: lvl = 9'($urandom_range(0, 256));
        endcase
    endtask

    task automatic run_phase(logic [7:0] bp, logic [7:0] ap, logic [3:0] ab, int n,
                             bit fast_tx, bit fast_rx, bit hold);
        logic [lbad_pkg::OP_W-1:0]    op;
        logic [lbad_pkg::LEVEL_W-1:0] lvl;
        logic [3:0]                   junk;
        settle_idle();
        junk = 4'($urandom_range(0, 15));
        write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
        write_reg(lbad_pkg::CFG_BLINK_PERIOD, bp);
        write_reg(lbad_pkg::CFG_ALERT_PERIOD, ap);
        write_reg(lbad_pkg::CFG_ALERT_BLINKS, {junk, ab});
        i_cfg_valid <= 1'b0;
        phases++;
        tx_eager = fast_tx;
        rx_eager = fast_rx;
        rx_hold = hold;
        repeat (n) begin
            pick_request(op, lvl);
            send_request(op, lvl);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [7:0] rb;
        logic [7:0] ra;
        logic [3:0] rc;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(lbad_pkg::OP_TICK, 9'h1FF);
        send_request(lbad_pkg::OP_SET_LEVEL, 9'd511);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        send_request(lbad_pkg::OP_SET_LEVEL, 9'd129);
        send_request(lbad_pkg::OP_FOCUS, 9'h0AA);
        send_request(lbad_pkg::OP_TICK, 9'h155);
        send_request(lbad_pkg::OP_SET_LEVEL, 9'd128);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        send_request(OP_SPARE_LO, 9'h1FF);
        send_request(OP_SPARE_HI, 9'h155);
        send_request(lbad_pkg::OP_ALERT, 9'd0);
        send_request(lbad_pkg::OP_ALERT, 9'd0);
        send_request(lbad_pkg::OP_FOCUS, 9'd0);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        send_request(lbad_pkg::OP_VALUE, 9'd0);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        send_request(lbad_pkg::OP_BLINK_ONCE, 9'd0);
        send_request(lbad_pkg::OP_BLINK_ONCE, 9'd0);
        send_request(lbad_pkg::OP_ALERT, 9'd0);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        send_request(lbad_pkg::OP_SET_LEVEL, 9'd0);
        send_request(lbad_pkg::OP_VALUE, 9'd0);
        send_request(lbad_pkg::OP_BLINK_ONCE, 9'd0);
        send_request(lbad_pkg::OP_TICK, 9'd0);
        s_axis_tvalid <= 1'b0;

        run_phase(8'd1, 8'd1, 4'd1, 140, 1'b0, 1'b0, 1'b0);
        run_phase(8'd0, 8'd0, 4'd0, 140, 1'b1, 1'b0, 1'b0);
        run_phase(8'd2, 8'd3, 4'd2, 160, 1'b0, 1'b1, 1'b0);
        run_phase(8'd255, 8'd255, 4'd15, 120, 1'b1, 1'b1, 1'b0);
        run_phase(8'd1, 8'd1, 4'd15, 160, 1'b1, 1'b0, 1'b1);
        run_phase(8'd5, 8'd2, 4'd3, 160, 1'b0, 1'b0, 1'b0);
        run_phase(8'd3, 8'd1, 4'd1, 160, 1'b0, 1'b1, 1'b0);
        repeat (4) begin
            rb = 8'($urandom_range(0, 8));
            ra = 8'($urandom_range(0, 8));
            rc = 4'($urandom_range(0, 6));
            run_phase(rb, ra, rc, 130, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'b0);
        end

        settle_idle();
        $display("Covered %0d requests over %0d register settings; %0d ticks checked",
                 sb.requests, phases + 1, sb.ticks_seen);
        $display("Ticks by mode value/focus/alert/once: %0d/%0d/%0d/%0d;",
                 sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
                 " returns alert %0d, once %0d", sb.alert_returns, sb.once_returns);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lbad_pkg.sv
hw/rtl/lbad_in_stage.sv
hw/rtl/lbad_core.sv
hw/rtl/lbad_out_stage.sv
hw/rtl/led_blink_alert_mode_driver_core.sv
bench/led_blink_alert_mode_driver_core_test.sv
